[sv/vec3_arithmetic_unit_defines.svh]
// Assertion macros used by the vector unit top level.
`ifndef VEC3_ARITHMETIC_UNIT_DEFINES_SVH
`define VEC3_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset
`define V3AU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Checked on every edge, reset included
`define V3AU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define V3AU_ASSERT(lbl, clk, rst_n, prop, msg)
`define V3AU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/v3au_pkg.sv]
// Types, constants, clamp and step functions of the Q16.16 vector unit.
`timescale 1ns / 1ps
package v3au_pkg;

    localparam int Q_W         = 32;              // Q16.16 word
    localparam int F_W         = 16;              // fraction bits
    localparam int P_W         = 2 * Q_W;         // full product
    localparam int T_W         = P_W - F_W;       // truncated product
    localparam int ACC_W       = T_W + 2;         // sum of three truncated products
    localparam int RAD_W       = P_W;             // square root radicand
    localparam int SQ_ROOT_W   = RAD_W / 2;
    localparam int SQ_REM_W    = SQ_ROOT_W + 1;
    localparam int SQRT_STAGES = SQ_ROOT_W;       // one root bit per stage
    localparam int DVD_W       = Q_W + F_W;       // |a| * 2^16
    localparam int DVS_W       = SQ_ROOT_W;       // length as divisor
    localparam int DIV_STAGES  = DVD_W;           // one quotient bit per stage
    localparam int EPS_W       = 16;
    localparam int N_MUL       = 6;
    localparam int N_LANE      = 3;

    localparam logic [EPS_W-1:0]     EPS_RESET = EPS_W'(1);
    localparam logic signed [Q_W-1:0] Q_MAX    = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN    = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [2:0] {
        KIND_ADD   = 3'd0,
        KIND_SUB   = 3'd1,
        KIND_SCALE = 3'd2,
        KIND_DOT   = 3'd3,
        KIND_CROSS = 3'd4,
        KIND_LEN   = 3'd5,
        KIND_NORM  = 3'd6,
        KIND_EQ    = 3'd7
    } kind_t;

    typedef logic signed [Q_W-1:0] q_t;

    typedef struct packed {
        q_t   r_x;
        q_t   r_y;
        q_t   r_z;
        q_t   r_scalar;
        logic is_equal;
        logic overflow;
    } res_t;

    // Travels alongside the square root
    typedef struct packed {
        kind_t                          kind;
        res_t                           res;
        logic [N_LANE-1:0]              neg;
        logic [N_LANE-1:0][DVD_W-1:0]   mag;
    } side_t;

    // Travels alongside the divider
    typedef struct packed {
        kind_t             kind;
        res_t              res;
        logic [N_LANE-1:0] neg;
        logic              do_norm;
    } fin_t;

    typedef struct packed {
        logic ov;
        q_t   val;
    } sat_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [DVD_W-1:0] quo;
    } dv_t;

    // Clamp a wide signed value to Q16.16
    function automatic sat_t sat_q(input logic signed [ACC_W-1:0] v);
        sat_t r;
        if (v[ACC_W-1:Q_W-1] == {(ACC_W-Q_W+1){v[ACC_W-1]}}) begin
            r.ov  = 1'b0;
            r.val = v[Q_W-1:0];
        end
        else if (v[ACC_W-1]) begin
            r.ov  = 1'b1;
            r.val = Q_MIN;
        end
        else begin
            r.ov  = 1'b1;
            r.val = Q_MAX;
        end
        return r;
    endfunction

    // One digit of the restoring square root
    function automatic sq_t sqrt_step(input logic [SQ_REM_W-1:0] rem,
                                      input logic [SQ_ROOT_W-1:0] root,
                                      input logic [1:0] bits);
        logic [SQ_REM_W:0] sh;
        logic [SQ_REM_W:0] trial;
        logic [SQ_REM_W:0] diff;
        sq_t r;
        sh    = {rem[SQ_ROOT_W-1:0], bits};
        trial = {root, 2'b01};
        diff  = sh - trial;
        if (sh >= trial) begin
            r.rem  = diff[SQ_REM_W-1:0];
            r.root = {root[SQ_ROOT_W-2:0], 1'b1};
        end
        else begin
            r.rem  = sh[SQ_REM_W-1:0];
            r.root = {root[SQ_ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // One bit of the restoring divider
    function automatic dv_t div_step(input logic [DVS_W-1:0] rem,
                                     input logic [DVD_W-1:0] quo,
                                     input logic [DVS_W-1:0] dvs);
        logic [DVS_W:0] sh;
        logic [DVS_W:0] diff;
        dv_t r;
        sh   = {rem, quo[DVD_W-1]};
        diff = sh - {1'b0, dvs};
        if (sh >= {1'b0, dvs}) begin
            r.rem = diff[DVS_W-1:0];
            r.quo = {quo[DVD_W-2:0], 1'b1};
        end
        else begin
            r.rem = sh[DVS_W-1:0];
            r.quo = {quo[DVD_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[sv/v3au_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module v3au_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [v3au_pkg::RAD_W-1:0]     rad,
    output logic                           out_valid,
    output logic [v3au_pkg::SQ_ROOT_W-1:0] root
);

    localparam int N = v3au_pkg::SQRT_STAGES;

    logic [N-1:0]                   vld_reg;
    logic [v3au_pkg::SQ_ROOT_W-1:0] root_reg [N];
    logic [v3au_pkg::SQ_REM_W-1:0]  rem_reg  [N-1];
    logic [v3au_pkg::RAD_W-1:0]     rad_reg  [N-1];
    v3au_pkg::sq_t                  step_next [N];

    // Per-stage digit
    always_comb
    begin
        step_next[0] = v3au_pkg::sqrt_step('0, '0, rad[v3au_pkg::RAD_W-1 -: 2]);
        for (int k = 1; k < N; k++)
        begin
            step_next[k] = v3au_pkg::sqrt_step(rem_reg[k-1], root_reg[k-1],
                                               rad_reg[k-1][v3au_pkg::RAD_W-1-2*k -: 2]);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                root_reg[k] <= step_next[k].root;
            end
            for (int k = 0; k < N - 1; k++)
            begin
                rem_reg[k] <= step_next[k].rem;
            end
            rad_reg[0] <= rad;
            for (int k = 1; k < N - 1; k++)
            begin
                rad_reg[k] <= rad_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];

endmodule

[sv/v3au_div.sv]
// Three-lane pipelined unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps
module v3au_div (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             en,
    input  logic                                             in_valid,
    input  logic [v3au_pkg::N_LANE-1:0][v3au_pkg::DVD_W-1:0] dvd,
    input  logic [v3au_pkg::DVS_W-1:0]                       dvs,
    output logic                                             out_valid,
    output logic [v3au_pkg::N_LANE-1:0][v3au_pkg::DVD_W-1:0] quo
);

    localparam int N = v3au_pkg::DIV_STAGES;
    localparam int L = v3au_pkg::N_LANE;

    logic [N-1:0]               vld_reg;
    logic [v3au_pkg::DVD_W-1:0] quo_reg  [N][L];
    logic [v3au_pkg::DVS_W-1:0] rem_reg  [N-1][L];
    logic [v3au_pkg::DVS_W-1:0] dvs_reg  [N-1];
    v3au_pkg::dv_t              step_next [N][L];

    // Per-stage, per-lane bit
    always_comb
    begin
        for (int j = 0; j < L; j++)
        begin
            step_next[0][j] = v3au_pkg::div_step('0, dvd[j], dvs);
        end
        for (int k = 1; k < N; k++)
        begin
            for (int j = 0; j < L; j++)
            begin
                step_next[k][j] = v3au_pkg::div_step(rem_reg[k-1][j], quo_reg[k-1][j],
                                                     dvs_reg[k-1]);
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                for (int j = 0; j < L; j++)
                begin
                    quo_reg[k][j] <= step_next[k][j].quo;
                end
            end
            for (int k = 0; k < N - 1; k++)
            begin
                for (int j = 0; j < L; j++)
                begin
                    rem_reg[k][j] <= step_next[k][j].rem;
                end
            end
            dvs_reg[0] <= dvs;
            for (int k = 1; k < N - 1; k++)
            begin
                dvs_reg[k] <= dvs_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    always_comb
    begin
        for (int j = 0; j < L; j++)
        begin
            quo[j] = quo_reg[N-1][j];
        end
    end

endmodule

[sv/vec3_arithmetic_unit.sv]
// Top level of the Q16.16 three-component vector arithmetic unit.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | to unit   | in_valid / in_stall  | kind, a_x a_y a_z, b_x b_y b_z
//  out     | from unit | out_valid / out_stall| r_x r_y r_z r_scalar, is_equal, overflow
//  cfg     | to unit   | cfg_valid / cfg_ready| cfg_data (epsilon)
//
//  One beat per cycle in and out unless stalled; path: operand select, multiply,
//  sum and clamp, 32 square root stages, 48 divider stages, output register.
//  The divider chain for normalize sets the latency; every kind takes the same path.
//  Reset clears all valid bits and sets epsilon to 1.
//  A two-entry output register and skid buffer park results; in_stall rises
//  only once the skid entry is full, and then the whole pipeline holds.
`timescale 1ns / 1ps
`include "vec3_arithmetic_unit_defines.svh"
module vec3_arithmetic_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // input beats
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       kind,
    input  logic signed [v3au_pkg::Q_W-1:0]  a_x,
    input  logic signed [v3au_pkg::Q_W-1:0]  a_y,
    input  logic signed [v3au_pkg::Q_W-1:0]  a_z,
    input  logic signed [v3au_pkg::Q_W-1:0]  b_x,
    input  logic signed [v3au_pkg::Q_W-1:0]  b_y,
    input  logic signed [v3au_pkg::Q_W-1:0]  b_z,
    // result beats
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [v3au_pkg::Q_W-1:0]  r_x,
    output logic signed [v3au_pkg::Q_W-1:0]  r_y,
    output logic signed [v3au_pkg::Q_W-1:0]  r_z,
    output logic signed [v3au_pkg::Q_W-1:0]  r_scalar,
    output logic                             is_equal,
    output logic                             overflow,
    // epsilon write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [v3au_pkg::EPS_W-1:0]       cfg_data
);

    localparam int QW = v3au_pkg::Q_W;
    localparam int TW = v3au_pkg::T_W;
    localparam int AW = v3au_pkg::ACC_W;
    localparam int NM = v3au_pkg::N_MUL;
    localparam int NL = v3au_pkg::N_LANE;
    localparam int SQ = v3au_pkg::SQRT_STAGES;
    localparam int DV = v3au_pkg::DIV_STAGES;

    logic                        en;
    logic [v3au_pkg::EPS_W-1:0]  eps_reg;

    // ---------------- epsilon register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= v3au_pkg::EPS_RESET;
        end
        else if (cfg_valid)
        begin
            eps_reg <= cfg_data;
        end
    end

    // ---------------- stage 1: operand select
    v3au_pkg::kind_t          in_kind;
    logic signed [QW-1:0]     a_in [NL];
    logic signed [QW-1:0]     b_in [NL];
    logic signed [QW-1:0]     mx_next [NM];
    logic signed [QW-1:0]     my_next [NM];

    logic                     s1_valid_reg;
    v3au_pkg::kind_t          s1_kind_reg;
    logic signed [QW-1:0]     s1_a_reg  [NL];
    logic signed [QW-1:0]     s1_b_reg  [NL];
    logic signed [QW-1:0]     s1_mx_reg [NM];
    logic signed [QW-1:0]     s1_my_reg [NM];

    assign in_kind = v3au_pkg::kind_t'(kind);
    assign a_in[0] = a_x;
    assign a_in[1] = a_y;
    assign a_in[2] = a_z;
    assign b_in[0] = b_x;
    assign b_in[1] = b_y;
    assign b_in[2] = b_z;

    always_comb
    begin
        for (int i = 0; i < NM; i++)
        begin
            mx_next[i] = '0;
            my_next[i] = '0;
        end
        case (in_kind)
            v3au_pkg::KIND_SCALE:
            begin
                for (int i = 0; i < NL; i++)
                begin
                    mx_next[i] = a_in[i];
                    my_next[i] = b_x;
                end
            end
            v3au_pkg::KIND_DOT:
            begin
                for (int i = 0; i < NL; i++)
                begin
                    mx_next[i] = a_in[i];
                    my_next[i] = b_in[i];
                end
            end
            v3au_pkg::KIND_CROSS:
            begin
                mx_next[0] = a_y;  my_next[0] = b_z;
                mx_next[1] = a_z;  my_next[1] = b_y;
                mx_next[2] = a_z;  my_next[2] = b_x;
                mx_next[3] = a_x;  my_next[3] = b_z;
                mx_next[4] = a_x;  my_next[4] = b_y;
                mx_next[5] = a_y;  my_next[5] = b_x;
            end
            v3au_pkg::KIND_LEN, v3au_pkg::KIND_NORM:
            begin
                for (int i = 0; i < NL; i++)
                begin
                    mx_next[i] = a_in[i];
                    my_next[i] = a_in[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- stage 2: multiply, add or subtract
    logic signed [v3au_pkg::P_W-1:0] prod [NM];
    logic                     s2_valid_reg;
    v3au_pkg::kind_t          s2_kind_reg;
    logic signed [QW-1:0]     s2_a_reg  [NL];
    logic signed [TW-1:0]     s2_p_reg  [NM];
    logic signed [QW:0]       s2_as_reg [NL];
    logic signed [QW:0]       as_next   [NL];

    always_comb
    begin
        for (int i = 0; i < NM; i++)
        begin
            prod[i] = s1_mx_reg[i] * s1_my_reg[i];
        end
        for (int i = 0; i < NL; i++)
        begin
            if (s1_kind_reg == v3au_pkg::KIND_ADD)
            begin
                as_next[i] = {s1_a_reg[i][QW-1], s1_a_reg[i]} + {s1_b_reg[i][QW-1], s1_b_reg[i]};
            end
            else
            begin
                as_next[i] = {s1_a_reg[i][QW-1], s1_a_reg[i]} - {s1_b_reg[i][QW-1], s1_b_reg[i]};
            end
        end
    end

    // ---------------- stage 3: sums, clamps, equality, root and divider operands
    v3au_pkg::side_t                 side_next;
    logic [v3au_pkg::RAD_W-1:0]      rad_next;
    logic                            s3_valid_reg;
    v3au_pkg::side_t                 s3_side_reg;
    logic [v3au_pkg::RAD_W-1:0]      s3_rad_reg;

    always_comb
    begin
        logic signed [AW-1:0] pe [NM];
        logic signed [AW-1:0] vx;
        logic signed [AW-1:0] vy;
        logic signed [AW-1:0] vz;
        logic signed [AW-1:0] vs;
        logic signed [AW-1:0] psum;
        logic [QW:0]          dmag;
        logic [QW-1:0]        amag;
        logic                 eq;
        v3au_pkg::sat_t       sx;
        v3au_pkg::sat_t       sy;
        v3au_pkg::sat_t       sz;
        v3au_pkg::sat_t       ss;

        for (int i = 0; i < NM; i++)
        begin
            pe[i] = {{(AW-TW){s2_p_reg[i][TW-1]}}, s2_p_reg[i]};
        end
        psum = pe[0] + pe[1] + pe[2];
        vx = '0;
        vy = '0;
        vz = '0;
        vs = '0;
        case (s2_kind_reg)
            v3au_pkg::KIND_ADD, v3au_pkg::KIND_SUB:
            begin
                vx = {{(AW-QW-1){s2_as_reg[0][QW]}}, s2_as_reg[0]};
                vy = {{(AW-QW-1){s2_as_reg[1][QW]}}, s2_as_reg[1]};
                vz = {{(AW-QW-1){s2_as_reg[2][QW]}}, s2_as_reg[2]};
            end
            v3au_pkg::KIND_SCALE:
            begin
                vx = pe[0];
                vy = pe[1];
                vz = pe[2];
            end
            v3au_pkg::KIND_DOT:
            begin
                vs = psum;
            end
            v3au_pkg::KIND_CROSS:
            begin
                vx = pe[0] - pe[1];
                vy = pe[2] - pe[3];
                vz = pe[4] - pe[5];
            end
            default:
            begin
            end
        endcase
        sx = v3au_pkg::sat_q(vx);
        sy = v3au_pkg::sat_q(vy);
        sz = v3au_pkg::sat_q(vz);
        ss = v3au_pkg::sat_q(vs);

        // equality: every |a - b| below epsilon
        eq = (s2_kind_reg == v3au_pkg::KIND_EQ);
        for (int i = 0; i < NL; i++)
        begin
            dmag = s2_as_reg[i][QW] ? (QW+1)'(-s2_as_reg[i]) : s2_as_reg[i];
            if (!(dmag < {{(QW+1-v3au_pkg::EPS_W){1'b0}}, eps_reg}))
            begin
                eq = 1'b0;
            end
        end

        side_next.kind         = s2_kind_reg;
        side_next.res.r_x      = sx.val;
        side_next.res.r_y      = sy.val;
        side_next.res.r_z      = sz.val;
        side_next.res.r_scalar = ss.val;
        side_next.res.is_equal = eq;
        side_next.res.overflow = sx.ov | sy.ov | sz.ov | ss.ov;
        for (int i = 0; i < NL; i++)
        begin
            amag = s2_a_reg[i][QW-1] ? QW'(-s2_a_reg[i]) : s2_a_reg[i];
            side_next.neg[i] = s2_a_reg[i][QW-1];
            side_next.mag[i] = {amag, {v3au_pkg::F_W{1'b0}}};
        end
        // sum of squares scaled by 2^16
        rad_next = {psum[TW-1:0], {v3au_pkg::F_W{1'b0}}};
    end

    // ---------------- front stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg <= in_kind;
            for (int i = 0; i < NL; i++)
            begin
                s1_a_reg[i]  <= a_in[i];
                s1_b_reg[i]  <= b_in[i];
                s2_a_reg[i]  <= s1_a_reg[i];
                s2_as_reg[i] <= as_next[i];
            end
            for (int i = 0; i < NM; i++)
            begin
                s1_mx_reg[i] <= mx_next[i];
                s1_my_reg[i] <= my_next[i];
                s2_p_reg[i]  <= prod[i][v3au_pkg::P_W-1:v3au_pkg::F_W];
            end
            s2_kind_reg <= s1_kind_reg;
            s3_side_reg <= side_next;
            s3_rad_reg  <= rad_next;
        end
    end

    // ---------------- square root with matching side delay
    logic                             sq_valid;
    logic [v3au_pkg::SQ_ROOT_W-1:0]   sq_root;
    v3au_pkg::side_t                  sq_side_reg [SQ];

    v3au_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .rad       (s3_rad_reg),
        .out_valid (sq_valid),
        .root      (sq_root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= s3_side_reg;
            for (int k = 1; k < SQ; k++)
            begin
                sq_side_reg[k] <= sq_side_reg[k-1];
            end
        end
    end

    // length result and normalise decision
    v3au_pkg::fin_t fin_next;
    v3au_pkg::side_t sq_out;

    assign sq_out = sq_side_reg[SQ-1];

    always_comb
    begin
        fin_next.kind    = sq_out.kind;
        fin_next.res     = sq_out.res;
        fin_next.neg     = sq_out.neg;
        fin_next.do_norm = (sq_out.kind == v3au_pkg::KIND_NORM) && (sq_root != '0) &&
                           (sq_root >= {{(v3au_pkg::SQ_ROOT_W-v3au_pkg::EPS_W){1'b0}}, eps_reg});
        if (sq_out.kind == v3au_pkg::KIND_LEN)
        begin
            fin_next.res.r_scalar = sq_root[QW-1] ? v3au_pkg::Q_MAX : $signed(sq_root[QW-1:0]);
            fin_next.res.overflow = sq_root[QW-1];
        end
    end

    // ---------------- divider with matching side delay
    logic                              dv_valid;
    logic [NL-1:0][v3au_pkg::DVD_W-1:0] dv_quo;
    v3au_pkg::fin_t                    dv_side_reg [DV];

    v3au_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .dvd       (sq_out.mag),
        .dvs       (sq_root),
        .out_valid (dv_valid),
        .quo       (dv_quo)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= fin_next;
            for (int k = 1; k < DV; k++)
            begin
                dv_side_reg[k] <= dv_side_reg[k-1];
            end
        end
    end

    // final result: signed, clamped quotients for normalise
    v3au_pkg::res_t res_final;
    v3au_pkg::fin_t dv_out;

    assign dv_out = dv_side_reg[DV-1];

    always_comb
    begin
        logic signed [AW-1:0] qv;
        v3au_pkg::sat_t       sq [NL];
        res_final = dv_out.res;
        for (int i = 0; i < NL; i++)
        begin
            qv = {{(AW-v3au_pkg::DVD_W){1'b0}}, dv_quo[i]};
            if (dv_out.neg[i])
            begin
                qv = -qv;
            end
            sq[i] = v3au_pkg::sat_q(qv);
        end
        if (dv_out.do_norm)
        begin
            res_final.r_x      = sq[0].val;
            res_final.r_y      = sq[1].val;
            res_final.r_z      = sq[2].val;
            res_final.overflow = sq[0].ov | sq[1].ov | sq[2].ov;
        end
    end

    // ---------------- output register and skid buffer
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    logic           take;
    logic           load_new;
    logic           load_skid;
    logic           skid_load;
    v3au_pkg::res_t out_res_reg;
    v3au_pkg::res_t skid_res_reg;

    assign en       = ~skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign take     = out_valid_reg & ~out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_new        = 1'b0;
        load_skid       = 1'b0;
        skid_load       = 1'b0;
        if (en && dv_valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                load_new       = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_load       = 1'b1;
            end
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_new)
        begin
            out_res_reg <= res_final;
        end
        else if (load_skid)
        begin
            out_res_reg <= skid_res_reg;
        end
        if (skid_load)
        begin
            skid_res_reg <= res_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign r_x       = out_res_reg.r_x;
    assign r_y       = out_res_reg.r_y;
    assign r_z       = out_res_reg.r_z;
    assign r_scalar  = out_res_reg.r_scalar;
    assign is_equal  = out_res_reg.is_equal;
    assign overflow  = out_res_reg.overflow;

    // ---------------- checks
    `V3AU_ASSERT_ALWAYS(a_skid_needs_out, clk, skid_valid_reg |-> out_valid_reg, "skid full with output empty")
    `V3AU_ASSERT(a_skid_holds, clk, rst_n, (skid_valid_reg && out_stall) |=> skid_valid_reg, "skid beat lost under stall")
    `V3AU_ASSERT(a_equal_clean, clk, rst_n, (out_valid_reg && is_equal) |-> (!overflow && r_scalar == '0), "equal result carries overflow or scalar")

endmodule
